FILE: rtl/core/ckh_pkg.sv
package ckh_pkg;

    // Field widths
    localparam int BASE_W      = 8;
    localparam int KLEN_W      = 5;
    localparam int KMER_W      = 62;
    localparam int KMER_PAIRS  = KMER_W / 2;
    localparam int HASH_W      = 64;
    localparam int BUCKET_W    = 4;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 136;
    localparam int OUT_PAD_W   = OUT_TDATA_W - KMER_W - HASH_W - BUCKET_W;

    // Block constants
    localparam int BUCKET_COUNT  = 16;
    localparam int MAX_KMER      = 31;
    localparam int QUEUE_DEPTH   = 4;
    localparam logic [KLEN_W-1:0] KLEN_RESET = 5'd31;
    localparam logic [KLEN_W-1:0] FILL_MAX   = 5'd31;

    // ASCII bytes that map to a defined base
    localparam logic [BASE_W-1:0] CHAR_A = 8'h41;
    localparam logic [BASE_W-1:0] CHAR_C = 8'h43;
    localparam logic [BASE_W-1:0] CHAR_G = 8'h47;

    // Two-bit base codes
    localparam logic [1:0] BASE_A     = 2'd0;
    localparam logic [1:0] BASE_C     = 2'd1;
    localparam logic [1:0] BASE_G     = 2'd2;
    localparam logic [1:0] BASE_OTHER = 2'd3;

    // One queue entry: both strands after the base that completed a k-mer.
    typedef struct packed {
        logic [KMER_W-1:0] fwd;
        logic [KMER_W-1:0] rev;
    } t_kmer_pair;

    // Length clamp: zero acts as one, never above MAX_KMER or 31.
    function automatic logic [KLEN_W-1:0] eff_len(input logic [KLEN_W-1:0] v);
        logic [KLEN_W:0] w;
        w = {1'b0, v};
        if (w == '0) w = (KLEN_W+1)'(1);
        if (w > (KLEN_W+1)'(MAX_KMER)) w = (KLEN_W+1)'(MAX_KMER);
        if (w > (KLEN_W+1)'(31)) w = (KLEN_W+1)'(31);
        return w[KLEN_W-1:0];
    endfunction

endpackage

FILE: rtl/core/ckh_front.sv
module ckh_front
    import ckh_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [KLEN_W-1:0] i_cfg_wr_data,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [BASE_W-1:0] i_base_char,
    input  logic              i_seq_start,
    input  logic              i_q_full,
    output logic              o_push,
    output t_kmer_pair        o_entry
);

    logic [KLEN_W-1:0] r_len;
    logic [KLEN_W-1:0] r_fill;
    logic [KLEN_W-1:0] n_fill;
    logic [KMER_W-1:0] r_fwd;
    logic [KMER_W-1:0] r_rev;
    logic [KMER_W-1:0] n_fwd;
    logic [KMER_W-1:0] n_rev;
    logic [KMER_W-1:0] mask;
    logic [KMER_W-1:0] ins_vec;
    logic [1:0]        code;
    logic              accept;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;

    always_comb begin
        case (i_base_char)
            CHAR_A:  code = BASE_A;
            CHAR_C:  code = BASE_C;
            CHAR_G:  code = BASE_G;
            default: code = BASE_OTHER;
        endcase
    end

    // Pair i is live when i < length; the complemented base enters at pair length-1.
    always_comb begin
        for (int i = 0; i < KMER_PAIRS; i++) begin
            mask[2*i +: 2]    = (KLEN_W'(i) < r_len) ? 2'b11 : 2'b00;
            ins_vec[2*i +: 2] = (KLEN_W'(i) == r_len - KLEN_W'(1)) ? ~code : 2'b00;
        end
        n_fwd = {r_fwd[KMER_W-3:0], code} & mask;
        n_rev = ((r_rev >> 2) | ins_vec) & mask;
    end

    always_comb begin
        n_fill = i_seq_start ? '0 : r_fill;
        if (n_fill != FILL_MAX) n_fill = n_fill + KLEN_W'(1);
    end

    assign o_push      = accept && (n_fill >= r_len);
    assign o_entry.fwd = n_fwd;
    assign o_entry.rev = n_rev;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len  <= eff_len(KLEN_RESET);
            r_fill <= '0;
            r_fwd  <= '0;
            r_rev  <= '0;
        end else if (i_cfg_wr_en) begin
            r_len  <= eff_len(i_cfg_wr_data);
            r_fill <= '0;
        end else if (accept) begin
            r_fill <= n_fill;
            r_fwd  <= n_fwd;
            r_rev  <= n_rev;
        end
    end

endmodule

FILE: rtl/core/ckh_queue.sv
module ckh_queue
    import ckh_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_kmer_pair i_data,
    input  logic       i_pop,
    output logic       o_full,
    output logic       o_empty,
    output t_kmer_pair o_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_kmer_pair      r_mem [DEPTH];
    logic [AW-1:0]   r_wr_ptr;
    logic [AW-1:0]   r_rd_ptr;
    logic [AW:0]     r_count;
    logic            do_push;
    logic            do_pop;

    assign o_full  = (r_count == (AW+1)'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr_ptr] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH-1)) ? '0 : r_wr_ptr + AW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH-1)) ? '0 : r_rd_ptr + AW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + (AW+1)'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - (AW+1)'(1);
            end
        end
    end

endmodule

FILE: rtl/core/ckh_back.sv
module ckh_back
    import ckh_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_empty,
    input  t_kmer_pair          i_entry,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [KMER_W-1:0]   o_canon,
    output logic [HASH_W-1:0]   o_hash,
    output logic [BUCKET_W-1:0] o_bucket
);

    logic                r_vld1, r_vld2, r_vld3, r_vld4, r_vld5;
    logic [KMER_W-1:0]   r_canon1, r_canon2, r_canon3, r_canon4, r_canon5;
    logic [HASH_W-1:0]   r_h2, r_h3, r_h4, r_h5;
    logic [BUCKET_W-1:0] r_bucket5;
    logic [KMER_W-1:0]   n_canon1;
    logic [HASH_W-1:0]   n_h2, n_h3, n_h4, n_h5;
    logic [HASH_W-1:0]   x1, t3, t4, t5;
    logic                advance;

    // The whole pipe moves together whenever the output stage is free or drained.
    assign advance = !r_vld5 || i_ready;
    assign o_pop   = advance && !i_q_empty;

    always_comb begin
        n_canon1 = (i_entry.fwd < i_entry.rev) ? i_entry.fwd : i_entry.rev;
        x1   = {{(HASH_W-KMER_W){1'b0}}, r_canon1};
        n_h2 = (~x1) + (x1 << 21);
        t3   = r_h2 ^ (r_h2 >> 24);
        n_h3 = (t3 + (t3 << 3)) + (t3 << 8);
        t4   = r_h3 ^ (r_h3 >> 14);
        n_h4 = (t4 + (t4 << 2)) + (t4 << 4);
        t5   = r_h4 ^ (r_h4 >> 28);
        n_h5 = t5 + (t5 << 31);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
            r_vld4 <= 1'b0;
            r_vld5 <= 1'b0;
        end else if (advance) begin
            r_vld1 <= !i_q_empty;
            r_vld2 <= r_vld1;
            r_vld3 <= r_vld2;
            r_vld4 <= r_vld3;
            r_vld5 <= r_vld4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_canon1  <= n_canon1;
            r_canon2  <= r_canon1;
            r_h2      <= n_h2;
            r_canon3  <= r_canon2;
            r_h3      <= n_h3;
            r_canon4  <= r_canon3;
            r_h4      <= n_h4;
            r_canon5  <= r_canon4;
            r_h5      <= n_h5;
            r_bucket5 <= BUCKET_W'(n_h5 % BUCKET_COUNT);
        end
    end

    assign o_valid  = r_vld5;
    assign o_canon  = r_canon5;
    assign o_hash   = r_h5;
    assign o_bucket = r_bucket5;

endmodule

FILE: rtl/core/canonical_kmer_hasher_core.sv
// Rolling canonical k-mer hasher.
// Input stream: one ASCII base per beat on s_axis_tdata, with s_axis_tuser set on
// the first base of a new sequence. Output stream: one beat per full k-mer with the
// canonical k-mer, its 64-bit shift hash and the bucket (hash modulo 16).
// The k-mer length is written through i_cfg_wr_en / i_cfg_wr_data; the user must
// write it only while the block is idle, as the block does not enforce this. A
// write restarts the fill, so the next result needs a full new k-mer. Throughput
// is one beat per cycle in both directions while neither side stalls. A result
// reaches m_axis_tvalid after the front queue and the five register stages of
// the strand compare and the hash.
// Reset clears the strands, the fill count and all valid flags and loads length 31.
// When the receiver holds m_axis_tready low on a waiting result the hash pipe stops
// as a whole and the front keeps taking bases until its queue of QUEUE_DEPTH
// entries is full; then s_axis_tready drops until the receiver takes beats again.
// Bases that complete no k-mer are still blocked while the queue is full.
module canonical_kmer_hasher_core
    import ckh_pkg::*;
#(
    parameter int QUEUE_DEPTH = ckh_pkg::QUEUE_DEPTH
)
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_wr_en,
    input  logic [KLEN_W-1:0]      i_cfg_wr_data,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [7:0] base_char
    input  logic                   s_axis_tuser,   // [0] sequence_start
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata    // [61:0] canonical_kmer,
                                                   // [125:62] kmer_hash,
                                                   // [129:126] bucket, rest zero
);

    t_kmer_pair          push_entry;
    t_kmer_pair          pop_entry;
    logic                push;
    logic                pop;
    logic                q_full;
    logic                q_empty;
    logic [KMER_W-1:0]   canon;
    logic [HASH_W-1:0]   hash;
    logic [BUCKET_W-1:0] bucket;

    ckh_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_base_char   (s_axis_tdata[BASE_W-1:0]),
        .i_seq_start   (s_axis_tuser),
        .i_q_full      (q_full),
        .o_push        (push),
        .o_entry       (push_entry)
    );

    ckh_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_entry),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_data  (pop_entry)
    );

    ckh_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_entry   (pop_entry),
        .o_pop     (pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_canon   (canon),
        .o_hash    (hash),
        .o_bucket  (bucket)
    );

    assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, bucket, hash, canon};

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import ckh_pkg::*;

    localparam int DIR_ROWS     = 24;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 219;
    localparam int DRAIN_CYCLES = 16;
    localparam int CYCLE_LIMIT  = 200000;

    typedef enum logic [1:0] {
        CHK_PRED,
        CHK_NONE,
        CHK_KMER
    } t_chk;

    typedef struct packed {
        logic [KLEN_W-1:0] klen;
        logic [BASE_W-1:0] ch;
        logic              st;
        t_chk              chk;
        logic [KMER_W-1:0] kmer;
    } t_stim_row;

    typedef struct packed {
        logic [BUCKET_W-1:0] bucket;
        logic [HASH_W-1:0]   hash;
        logic [KMER_W-1:0]   kmer;
    } t_kmer_hit;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_wr_en = 1'b0;
    logic [KLEN_W-1:0]      i_cfg_wr_data = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // [7:0] base_char
    logic                   s_axis_tuser = 1'b0; // [0] sequence_start
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;        // [61:0] canonical_kmer,
                                                 // [125:62] kmer_hash,
                                                 // [129:126] bucket, rest zero

    // Predictor state.
    logic [KLEN_W-1:0] kmer_len = KLEN_RESET;
    logic [63:0]       strand_fwd = '0;
    logic [63:0]       strand_rev = '0;
    logic [KLEN_W-1:0] bases_seen = '0;

    t_kmer_hit pending_hits [$];
    t_kmer_hit want;
    int        err_cnt = 0;
    int        cycle_cnt = 0;
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;

    logic [BASE_W-1:0] nt_chars [4] = '{CHAR_A, CHAR_C, CHAR_G, 8'h54};
    int                phase_len [PHASES] = '{31, 1, 0, -1, 2, 30, -1, 5};

    // Directed rows: reset length, single-base k-mers over every base code and
    // odd bytes, zero length, a palindrome, and the restart after a length write.
    t_stim_row dir_rows [DIR_ROWS] = '{
        '{5'd31, CHAR_A, 1'b1, CHK_NONE, 62'd0},
        '{5'd31, CHAR_C, 1'b0, CHK_NONE, 62'd0},
        '{5'd31, CHAR_G, 1'b0, CHK_NONE, 62'd0},
        '{5'd1,  CHAR_A, 1'b1, CHK_KMER, 62'd0},
        '{5'd1,  CHAR_C, 1'b0, CHK_KMER, 62'd1},
        '{5'd1,  CHAR_G, 1'b0, CHK_KMER, 62'd1},
        '{5'd1,  8'h54,  1'b0, CHK_KMER, 62'd0},
        '{5'd1,  8'h00,  1'b0, CHK_KMER, 62'd0},
        '{5'd1,  8'hFF,  1'b1, CHK_KMER, 62'd0},
        '{5'd1,  8'h61,  1'b0, CHK_KMER, 62'd0},
        '{5'd1,  8'hC1,  1'b0, CHK_KMER, 62'd0},
        '{5'd0,  CHAR_G, 1'b1, CHK_KMER, 62'd1},
        '{5'd0,  CHAR_C, 1'b0, CHK_KMER, 62'd1},
        '{5'd2,  CHAR_A, 1'b1, CHK_NONE, 62'd0},
        '{5'd2,  CHAR_C, 1'b0, CHK_KMER, 62'd1},
        '{5'd2,  CHAR_G, 1'b1, CHK_NONE, 62'd0},
        '{5'd2,  8'h54,  1'b0, CHK_KMER, 62'd1},
        '{5'd2,  CHAR_A, 1'b0, CHK_KMER, 62'd12},
        '{5'd3,  CHAR_C, 1'b0, CHK_NONE, 62'd0},
        '{5'd3,  CHAR_C, 1'b0, CHK_NONE, 62'd0},
        '{5'd3,  CHAR_C, 1'b0, CHK_KMER, 62'd21},
        '{5'd3,  8'h54,  1'b1, CHK_NONE, 62'd0},
        '{5'd3,  8'h54,  1'b0, CHK_NONE, 62'd0},
        '{5'd3,  8'h54,  1'b0, CHK_KMER, 62'd0}
    };

    canonical_kmer_hasher_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [HASH_W-1:0] wang64(input logic [HASH_W-1:0] v);
        logic [HASH_W-1:0] x;
        x = ~v + (v << 21);
        x = x ^ (x >> 24);
        x = x + (x << 3) + (x << 8);
        x = x ^ (x >> 14);
        x = x + (x << 2) + (x << 4);
        x = x ^ (x >> 28);
        x = x + (x << 31);
        return x;
    endfunction

    function automatic t_kmer_hit hash_kmer(input logic [KMER_W-1:0] kmer);
        t_kmer_hit hit;
        hit.kmer   = kmer;
        hit.hash   = wang64({2'b00, kmer});
        hit.bucket = BUCKET_W'(hit.hash % BUCKET_COUNT);
        return hit;
    endfunction

    // Shifts one base into both strands; returns 1 when a full k-mer is ready.
    function automatic logic roll_base(input logic [BASE_W-1:0] ch, input logic st,
                                       output t_kmer_hit hit);
        logic [KLEN_W-1:0] n;
        logic [63:0]       mask;
        logic [1:0]        code;
        n = (kmer_len == '0) ? KLEN_W'(1) : kmer_len;
        mask = (64'd1 << (2 * n)) - 64'd1;
        case (ch)
            CHAR_A:  code = BASE_A;
            CHAR_C:  code = BASE_C;
            CHAR_G:  code = BASE_G;
            default: code = BASE_OTHER;
        endcase
        if (st) bases_seen = '0;
        strand_fwd = ((strand_fwd << 2) | 64'(code)) & mask;
        strand_rev = ((strand_rev >> 2) | (64'(BASE_OTHER - code) << (2 * (n - 1)))) & mask;
        if (bases_seen != FILL_MAX) bases_seen = bases_seen + 1'b1;
        hit = hash_kmer(KMER_W'((strand_fwd < strand_rev) ? strand_fwd : strand_rev));
        return (bases_seen >= n);
    endfunction

    task automatic send_base(input logic [BASE_W-1:0] ch, input logic st, input t_chk chk,
                             input logic [KMER_W-1:0] kmer);
        t_kmer_hit hit;
        logic      fired;
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ch;
        s_axis_tuser  <= st;
        do @(posedge i_clk); while (!s_axis_tready);
        fired = roll_base(ch, st, hit);
        case (chk)
            CHK_PRED: if (fired) pending_hits.insert(pending_hits.size(), hit);
            CHK_KMER: pending_hits.insert(pending_hits.size(), hash_kmer(kmer));
            default: ;
        endcase
    endtask

    // The length is only changed once the pipe has drained.
    task automatic write_kmer_len(input logic [KLEN_W-1:0] v);
        s_axis_tvalid <= 1'b0;
        while (pending_hits.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        kmer_len   = v;
        bases_seen = '0;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_hits.size() == 0) begin
                $display("%0t: unexpected beat, expected none, actual %h", $time, m_axis_tdata);
                err_cnt++;
            end else begin
                want = pending_hits.pop_front();
                if (m_axis_tdata[KMER_W-1:0] != want.kmer) begin
                    $display("%0t: canonical_kmer expected %h, actual %h", $time, want.kmer,
                             m_axis_tdata[KMER_W-1:0]);
                    err_cnt++;
                end
                if (m_axis_tdata[KMER_W +: HASH_W] != want.hash) begin
                    $display("%0t: kmer_hash expected %h, actual %h", $time, want.hash,
                             m_axis_tdata[KMER_W +: HASH_W]);
                    err_cnt++;
                end
                if (m_axis_tdata[KMER_W+HASH_W +: BUCKET_W] != want.bucket) begin
                    $display("%0t: bucket expected %h, actual %h", $time, want.bucket,
                             m_axis_tdata[KMER_W+HASH_W +: BUCKET_W]);
                    err_cnt++;
                end
                if (m_axis_tdata[OUT_TDATA_W-1 -: OUT_PAD_W] != '0) begin
                    $display("%0t: padding expected 0, actual %h", $time,
                             m_axis_tdata[OUT_TDATA_W-1 -: OUT_PAD_W]);
                    err_cnt++;
                end
            end
        end
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        int                left;
        int                run;
        int                eff;
        logic              clean;
        logic [BASE_W-1:0] ch;
        logic              st;
        logic [KLEN_W-1:0] len;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < DIR_ROWS; i++) begin
            if (dir_rows[i].klen != kmer_len) write_kmer_len(dir_rows[i].klen);
            send_base(dir_rows[i].ch, dir_rows[i].st, dir_rows[i].chk, dir_rows[i].kmer);
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            len = (phase_len[ph] < 0) ? KLEN_W'($urandom_range(31)) : KLEN_W'(phase_len[ph]);
            write_kmer_len(len);
            eff = (len == '0) ? 1 : int'(len);
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
                default: begin send_idle_pct = 11; recv_stall_pct = 11; end
            endcase
            // Mostly clean reads that run past the k-mer length, with some
            // byte noise and sequence starts at random points.
            left = PHASE_ITEMS;
            while (left > 0) begin
                clean = ($urandom_range(99) < 80);
                run = clean ? $urandom_range(1, 2 * eff + 12) : $urandom_range(1, 20);
                if (run > left) run = left;
                for (int j = 0; j < run; j++) begin
                    if (clean && $urandom_range(99) < 93) ch = nt_chars[$urandom_range(3)];
                    else ch = BASE_W'($urandom_range(255));
                    st = clean ? (j == 0) : 1'($urandom_range(1));
                    send_base(ch, st, CHK_PRED, '0);
                end
                left -= run;
            end
        end

        s_axis_tvalid <= 1'b0;
        while (pending_hits.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_cnt == 0) $display("simulation ok");
        else $display("simulation failed");
        $finish;
    end

endmodule
